// ----- sv/lphd_pkg.sv -----
// Package: types and codes for the linear probe hash dictionary.
`default_nettype none
package lphd_pkg;
  localparam int SLOTS_DEF     = 64;
  localparam int KEY_CHARS_DEF = 8;
  localparam logic [5:0] ITEM_LIMIT_RST = 6'd48;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] MARK_UNUSED  = 2'd0;
  localparam logic [1:0] MARK_IN_USE  = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [2:0] OUT_UPDATED   = 3'd0;
  localparam logic [2:0] OUT_INSERTED  = 3'd1;
  localparam logic [2:0] OUT_FOUND     = 3'd2;
  localparam logic [2:0] OUT_REMOVED   = 3'd3;
  localparam logic [2:0] OUT_NOT_FOUND = 3'd4;
  localparam logic [2:0] OUT_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [63:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [63:0] value_out;
  } out_word_t;
endpackage
`default_nettype wire

// ----- sv/linear_probe_hash_dictionary.sv -----
// Top level: open addressing hash dictionary with linear probing.
//
//  channel  ports                        handshake
//  in       start, busy, in_word         taken when start && !busy
//  out      out_valid, out_word          one-cycle strobe, no backpressure
//  cfg      cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
// The serial hash does one multiply-add a cycle, then each probed slot takes
// an address in S_RD, then a registered read and compare in S_CHK, over the
// single memory port. Insert of a new key below the item limit runs a second
// pass from the home slot, then a write in S_WR. The strobe is registered from
// S_DONE. Reset clears marks by a sweep over all SLOTS slots; busy stays high
// meanwhile. Clear all also sweeps every slot. The receiver cannot stall.
`default_nettype none
module linear_probe_hash_dictionary #(
  parameter int SLOTS     = lphd_pkg::SLOTS_DEF,
  parameter int KEY_CHARS = lphd_pkg::KEY_CHARS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire lphd_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output lphd_pkg::out_word_t      out_word,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [5:0]          cfg_data
);
  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_RD2   = 4'd6;
  localparam logic [3:0] S_CHK2  = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  op_r;
  logic [63:0] key_r, val_r;
  logic [3:0]  len_r, idx_r;
  logic [31:0] sum_r;
  logic [AW-1:0] home_r, pos_r, tomb_r;
  logic        tomb_ok_r;
  logic [CW-1:0] n_r;
  logic [6:0]  count_r;
  logic [5:0]  limit_r;
  logic [2:0]  outc_r;
  logic [63:0] vout_r;

  logic [1:0]  mark_mem [SLOTS];
  logic [63:0] key_mem  [SLOTS];
  logic [3:0]  len_mem  [SLOTS];
  logic [63:0] val_mem  [SLOTS];
  logic [1:0]  rd_mark;
  logic [63:0] rd_key, rd_val;
  logic [3:0]  rd_len;

  logic [3:0]  len_eff;
  logic [63:0] key_eff;
  logic [31:0] sum_nxt;
  logic [AW-1:0] pos_inc;
  logic        hit, lap_end;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    len_eff = (in_word.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : in_word.key_length;
    for (int b = 0; b < 8; b++) begin
      key_eff[b*8 +: 8] = (4'(b) < len_eff) ? in_word.key_bytes[b*8 +: 8] : 8'd0;
    end
  end

  // one multiply-add per character
  assign sum_nxt = sum_r * 32'(idx_r) + 32'(key_r[idx_r[2:0]*8 +: 8]);
  assign pos_inc = (32'(pos_r) == SLOTS - 1) ? '0 : pos_r + 1'b1;
  assign hit     = rd_mark == lphd_pkg::MARK_IN_USE && rd_key == key_r && rd_len == len_r;
  assign lap_end = (32'(n_r) == SLOTS - 1);

  // memory read port, registered
  always_ff @(posedge clk) begin
    rd_mark <= mark_mem[pos_r];
    rd_key  <= key_mem[pos_r];
    rd_len  <= len_mem[pos_r];
    rd_val  <= val_mem[pos_r];
  end

  logic       wr_mark_en, wr_all_en;
  logic [1:0] wr_mark;

  always_ff @(posedge clk) begin
    if (wr_mark_en) mark_mem[pos_r] <= wr_mark;
    if (wr_all_en) begin
      key_mem[pos_r] <= key_r;
      len_mem[pos_r] <= len_r;
    end
    if (wr_all_en || (state_r == S_CHK && hit && op_r == lphd_pkg::OP_INSERT))
      val_mem[pos_r] <= val_r;
  end

  always_comb begin
    state_nxt  = state_r;
    wr_mark_en = 1'b0;
    wr_all_en  = 1'b0;
    wr_mark    = lphd_pkg::MARK_UNUSED;
    case (state_r)
      S_CLR: begin
        wr_mark_en = 1'b1;
        if (32'(pos_r) == SLOTS - 1) state_nxt = (op_r == lphd_pkg::OP_CLEAR) ? S_DONE : S_IDLE;
      end
      S_IDLE: if (start) state_nxt = (in_word.operation == lphd_pkg::OP_CLEAR) ? S_CLR : S_HASH;
      S_HASH: if (idx_r == len_r) state_nxt = S_MOD;
      S_MOD:  state_nxt = S_RD;
      S_RD:   state_nxt = S_CHK;
      S_CHK: begin
        if (rd_mark == lphd_pkg::MARK_UNUSED || hit || lap_end) begin
          if (hit) begin
            if (op_r == lphd_pkg::OP_REMOVE) begin
              wr_mark_en = 1'b1;
              wr_mark    = lphd_pkg::MARK_DELETED;
            end
            state_nxt = S_DONE;
          end else if (op_r == lphd_pkg::OP_INSERT && count_r < 7'(limit_r)) begin
            state_nxt = S_RD2;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD2:  state_nxt = S_CHK2;
      S_CHK2: begin
        if (rd_mark == lphd_pkg::MARK_UNUSED || lap_end) begin
          if (tomb_ok_r || (rd_mark == lphd_pkg::MARK_DELETED)
              || rd_mark == lphd_pkg::MARK_UNUSED) state_nxt = S_WR;
          else state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD2;
        end
      end
      S_WR: begin
        wr_mark_en = 1'b1;
        wr_all_en  = 1'b1;
        wr_mark    = lphd_pkg::MARK_IN_USE;
        state_nxt  = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      pos_r     <= '0;
      op_r      <= lphd_pkg::OP_INSERT;
      count_r   <= '0;
      limit_r   <= lphd_pkg::ITEM_LIMIT_RST;
      out_valid <= 1'b0;
      tomb_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (cfg_valid && cfg_ready) limit_r <= cfg_data;
      case (state_r)
        S_CLR: pos_r <= pos_inc;
        S_IDLE: if (start) begin
          op_r   <= in_word.operation;
          key_r  <= key_eff;
          len_r  <= len_eff;
          val_r  <= in_word.value_in;
          sum_r  <= '0;
          idx_r  <= '0;
          pos_r  <= '0;
          outc_r <= lphd_pkg::OUT_NOT_FOUND;
          vout_r <= '0;
          if (in_word.operation == lphd_pkg::OP_CLEAR) begin
            count_r <= '0;
            outc_r  <= lphd_pkg::OUT_REMOVED;
          end
        end
        S_HASH: if (idx_r != len_r) begin
          sum_r <= sum_nxt;
          idx_r <= idx_r + 1'b1;
        end
        S_MOD: begin
          home_r    <= AW'(sum_r % SLOTS);
          pos_r     <= AW'(sum_r % SLOTS);
          n_r       <= '0;
          tomb_ok_r <= 1'b0;
        end
        S_CHK: begin
          if (hit) begin
            case (op_r)
              lphd_pkg::OP_SEARCH: begin
                outc_r <= lphd_pkg::OUT_FOUND;
                vout_r <= rd_val;
              end
              lphd_pkg::OP_REMOVE: outc_r <= lphd_pkg::OUT_REMOVED;
              default:             outc_r <= lphd_pkg::OUT_UPDATED;
            endcase
          end else if (rd_mark == lphd_pkg::MARK_UNUSED || lap_end) begin
            if (op_r == lphd_pkg::OP_INSERT) outc_r <= lphd_pkg::OUT_FULL;
            pos_r <= home_r;
            n_r   <= '0;
          end else begin
            pos_r <= pos_inc;
            n_r   <= n_r + 1'b1;
          end
        end
        S_CHK2: begin
          if (rd_mark == lphd_pkg::MARK_DELETED) begin
            tomb_r    <= pos_r;
            tomb_ok_r <= 1'b1;
          end
          if (rd_mark == lphd_pkg::MARK_UNUSED || lap_end) begin
            // last tombstone wins over the unused slot
            if (rd_mark == lphd_pkg::MARK_DELETED) pos_r <= pos_r;
            else if (tomb_ok_r) pos_r <= tomb_r;
          end else begin
            pos_r <= pos_inc;
            n_r   <= n_r + 1'b1;
          end
        end
        S_WR: begin
          count_r <= count_r + 1'b1;
          outc_r  <= lphd_pkg::OUT_INSERTED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_word.outcome   <= outc_r;
    out_word.value_out <= vout_r;
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(start && !busy)) else $error("strobe right after accept");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("not busy after accept");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (count_r < 7'(limit_r))) else $error("insert past limit");
  a_vout_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.outcome != lphd_pkg::OUT_FOUND |-> out_word.value_out == 64'd0)
    else $error("value out nonzero");
endmodule
`default_nettype wire
